[rtl/pid_conditional_integration_defines.svh]
// assertion macros for the pid conditional integration block
// used by the checker bound to the top level, no other dependencies
`ifndef PID_CONDITIONAL_INTEGRATION_DEFINES_SVH
`define PID_CONDITIONAL_INTEGRATION_DEFINES_SVH

// condition holds at every edge outside reset
`define PIDCI_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("pidci check failed");

// consequent holds at the edge after the antecedent
`define PIDCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pidci check failed");

// condition holds at every edge, reset included
`define PIDCI_ASSERT_ALWAYS(lbl, clk, cond) \
	lbl: assert property (@(posedge clk) (cond)) \
		else $error("pidci check failed");

`endif

[rtl/pidci_pkg.sv]
// shared types and constants of the pid conditional integration block
// no dependencies
package pidci_pkg;

	localparam int GAIN_W = 32;
	localparam int APB_AW = 5;
	localparam int QUEUE_AW = 2;

	typedef enum logic [2:0] {
		REG_PROP_GAIN,
		REG_INTEGRAL_GAIN,
		REG_DERIVATIVE_GAIN,
		REG_DRIVE_MIN,
		REG_DRIVE_MAX
	} reg_idx_t;

	typedef enum logic [1:0] {
		LIMIT_NONE,
		LIMIT_MAX,
		LIMIT_MIN
	} limit_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop;
		logic signed [GAIN_W-1:0] integ;
		logic signed [GAIN_W-1:0] deriv;
	} gains_t;

endpackage

[rtl/pidci_front.sv]
// front end: takes samples, forms error and measurement step, multiplies by the gains
// depends on pidci_pkg
module pidci_front #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_WIDTH = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [DATA_WIDTH-1:0]  target_value,
	input  logic signed [DATA_WIDTH-1:0]  measured_value,
	input  pidci_pkg::gains_t             gains,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ACC_WIDTH-1:0]   p_term,
	output logic signed [ACC_WIDTH-1:0]   i_step,
	output logic signed [ACC_WIDTH-1:0]   d_term
);

	localparam int PW = pidci_pkg::GAIN_W + DATA_WIDTH + 1;
	localparam int SW = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;
	localparam logic signed [SW-1:0] ACC_HI = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

	logic                         v_s1, v_s2;
	logic                         take_s1, take_s2;
	logic signed [DATA_WIDTH:0]   err_s1, d_diff_s1;
	logic signed [PW-1:0]         p_prod_s2, i_prod_s2, d_prod_s2;
	logic signed [DATA_WIDTH-1:0] last_measured_q;

	function automatic logic signed [ACC_WIDTH-1:0] sat_prod(input logic signed [PW-1:0] x);
		logic signed [SW-1:0] ext;
		ext = {{(SW-PW){x[PW-1]}}, x};
		if (ext > ACC_HI) begin
			return ACC_HI[ACC_WIDTH-1:0];
		end else if (ext < ACC_LO) begin
			return ACC_LO[ACC_WIDTH-1:0];
		end
		return ext[ACC_WIDTH-1:0];
	endfunction

	assign take_s2 = !v_s2 || out_ready;
	assign take_s1 = !v_s1 || take_s2;
	assign in_ready = take_s1;
	assign out_valid = v_s2;

	assign p_term = sat_prod(p_prod_s2);
	assign i_step = sat_prod(i_prod_s2);
	assign d_term = sat_prod(d_prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_measured_q <= '0;
		end else begin
			if (take_s1) begin
				v_s1 <= in_valid;
			end
			if (take_s2) begin
				v_s2 <= v_s1;
			end
			if (in_valid && take_s1) begin
				last_measured_q <= measured_value;
			end
		end
	end

	// derivative on measurement, sign folded into the difference
	always_ff @(posedge clk) begin
		if (in_valid && take_s1) begin
			err_s1 <= {target_value[DATA_WIDTH-1], target_value}
				- {measured_value[DATA_WIDTH-1], measured_value};
			d_diff_s1 <= {last_measured_q[DATA_WIDTH-1], last_measured_q}
				- {measured_value[DATA_WIDTH-1], measured_value};
		end
		if (v_s1 && take_s2) begin
			p_prod_s2 <= $signed(gains.prop) * err_s1;
			i_prod_s2 <= $signed(gains.integ) * err_s1;
			d_prod_s2 <= $signed(gains.deriv) * d_diff_s1;
		end
	end

endmodule

[rtl/pidci_queue.sv]
// small request queue between front and back end
// depends on pidci_pkg for its depth
module pidci_queue #(
	parameter int WIDTH = 144
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int AW = pidci_pkg::QUEUE_AW;
	localparam int DEPTH = 1 << AW;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push, pop;

	assign in_ready = count_q != (AW+1)'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_data = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

[rtl/pidci_back.sv]
// back end: integrator update, drive sum, clamp and output register
// depends on pidci_pkg
module pidci_back #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ACC_WIDTH-1:0]   p_term,
	input  logic signed [ACC_WIDTH-1:0]   i_step,
	input  logic signed [ACC_WIDTH-1:0]   d_term,
	input  logic signed [DATA_WIDTH-1:0]  drive_min,
	input  logic signed [DATA_WIDTH-1:0]  drive_max,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DATA_WIDTH-1:0]  drive,
	output pidci_pkg::limit_t             limit_state
);

	localparam int HW = DATA_WIDTH + FRAC_BITS;
	localparam int CW = ((HW > ACC_WIDTH) ? HW : ACC_WIDTH) + 1;

	logic signed [ACC_WIDTH-1:0]  integral_sum_q, isum_nxt;
	logic signed [ACC_WIDTH-1:0]  cand, part_sum, sum;
	logic signed [CW-1:0]         sum_x, hi_x, lo_x, shifted;
	logic signed [DATA_WIDTH-1:0] drive_nxt, drive_q;
	pidci_pkg::limit_t            limit_nxt, limit_q;
	logic                         out_valid_q, pop;

	function automatic logic signed [ACC_WIDTH-1:0] sat_add(
		input logic signed [ACC_WIDTH-1:0] a,
		input logic signed [ACC_WIDTH-1:0] b
	);
		logic signed [ACC_WIDTH:0] s;
		s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
			return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
				: {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end
		return s[ACC_WIDTH-1:0];
	endfunction

	assign cand = sat_add(integral_sum_q, i_step);
	assign part_sum = sat_add(p_term, cand);
	assign sum = sat_add(part_sum, d_term);

	assign sum_x = {{(CW-ACC_WIDTH){sum[ACC_WIDTH-1]}}, sum};
	assign hi_x = {{(CW-HW){drive_max[DATA_WIDTH-1]}}, drive_max, {FRAC_BITS{1'b0}}};
	assign lo_x = {{(CW-HW){drive_min[DATA_WIDTH-1]}}, drive_min, {FRAC_BITS{1'b0}}};
	assign shifted = sum_x >>> FRAC_BITS;

	// upper limit wins when the limits cross
	always_comb begin
		priority if (sum_x > hi_x) begin
			drive_nxt = drive_max;
			limit_nxt = pidci_pkg::LIMIT_MAX;
			isum_nxt = (cand < integral_sum_q) ? cand : integral_sum_q;
		end else if (sum_x < lo_x) begin
			drive_nxt = drive_min;
			limit_nxt = pidci_pkg::LIMIT_MIN;
			isum_nxt = (cand > integral_sum_q) ? cand : integral_sum_q;
		end else begin
			drive_nxt = shifted[DATA_WIDTH-1:0];
			limit_nxt = pidci_pkg::LIMIT_NONE;
			isum_nxt = cand;
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign pop = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign drive = drive_q;
	assign limit_state = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			integral_sum_q <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				integral_sum_q <= isum_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			drive_q <= drive_nxt;
			limit_q <= limit_nxt;
		end
	end

endmodule

[rtl/pid_conditional_integration.sv]
// top level of the pid conditional integration block: register file and stream glue
// depends on pidci_pkg, pidci_front, pidci_queue and pidci_back
//
// PID controller with derivative on measurement and conditional integration.
// s_axis carries one request per sample: setpoint and measurement. m_axis returns
// one result per request: the clamped drive in tdata and the limit state in tuser.
// Gains (signed Q16.16 with ki*Ts and kd/Ts folded in) and the drive limits are
// written over the APB port only while no request is in flight, a rule the block
// leaves to the user; reads return them. Requests pass the error and multiplier
// stages, the queue and the output register. One request is taken every cycle while
// m_axis is ready; the integrator update, three saturating adds and the limit compare
// form the critical path. A four-entry queue sits between the multiplier front end and
// the integrator back end. When the receiver stalls, the result register holds, the
// queue and front stages fill, and s_axis_tready drops; no result is lost.
// Reset clears the integrator, the last measurement, the gains, sets the limits
// to the full drive range and empties every stage.
module pid_conditional_integration #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// target_value, measured_value
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// drive
	output logic [((DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
	// limit_state
	output logic [1:0]                            m_axis_tuser,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pidci_pkg::APB_AW-1:0]          paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	localparam int OUT_TW = ((DATA_WIDTH+7)/8)*8;
	localparam int QW = 3 * ACC_WIDTH;

	pidci_pkg::gains_t            gains_q;
	logic signed [DATA_WIDTH-1:0] drive_min_q, drive_max_q;
	logic [2:0]                   reg_idx;
	logic                         wr_en;

	logic signed [DATA_WIDTH-1:0] target_value, measured_value;
	logic                         fq_valid, fq_ready, qb_valid, qb_ready;
	logic signed [ACC_WIDTH-1:0]  f_p, f_i, f_d;
	logic [QW-1:0]                q_out;
	logic signed [DATA_WIDTH-1:0] drive;
	logic [DATA_WIDTH-1:0]        drive_u;
	pidci_pkg::limit_t            limit_state;

	assign pready = 1'b1;
	assign reg_idx = paddr[pidci_pkg::APB_AW-1:2];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
			drive_min_q <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
			drive_max_q <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else if (wr_en) begin
			unique case (reg_idx)
				pidci_pkg::REG_PROP_GAIN:       gains_q.prop <= pwdata;
				pidci_pkg::REG_INTEGRAL_GAIN:   gains_q.integ <= pwdata;
				pidci_pkg::REG_DERIVATIVE_GAIN: gains_q.deriv <= pwdata;
				pidci_pkg::REG_DRIVE_MIN:       drive_min_q <= pwdata[DATA_WIDTH-1:0];
				pidci_pkg::REG_DRIVE_MAX:       drive_max_q <= pwdata[DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pidci_pkg::REG_PROP_GAIN:       prdata = gains_q.prop;
			pidci_pkg::REG_INTEGRAL_GAIN:   prdata = gains_q.integ;
			pidci_pkg::REG_DERIVATIVE_GAIN: prdata = gains_q.deriv;
			pidci_pkg::REG_DRIVE_MIN:       prdata = 32'(drive_min_q);
			pidci_pkg::REG_DRIVE_MAX:       prdata = 32'(drive_max_q);
			default:                        prdata = '0;
		endcase
	end

	assign target_value = s_axis_tdata[DATA_WIDTH-1:0];
	assign measured_value = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

	pidci_front #(
		.DATA_WIDTH(DATA_WIDTH),
		.ACC_WIDTH(ACC_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.target_value(target_value),
		.measured_value(measured_value),
		.gains(gains_q),
		.out_valid(fq_valid),
		.out_ready(fq_ready),
		.p_term(f_p),
		.i_step(f_i),
		.d_term(f_d)
	);

	pidci_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fq_valid),
		.in_ready(fq_ready),
		.in_data({f_d, f_i, f_p}),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_data(q_out)
	);

	pidci_back #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS),
		.ACC_WIDTH(ACC_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(qb_valid),
		.in_ready(qb_ready),
		.p_term(q_out[ACC_WIDTH-1:0]),
		.i_step(q_out[2*ACC_WIDTH-1:ACC_WIDTH]),
		.d_term(q_out[3*ACC_WIDTH-1:2*ACC_WIDTH]),
		.drive_min(drive_min_q),
		.drive_max(drive_max_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.drive(drive),
		.limit_state(limit_state)
	);

	assign drive_u = drive;
	assign m_axis_tdata = OUT_TW'(drive_u);
	assign m_axis_tuser = limit_state;

endmodule

[rtl/pidci_checker.sv]
// port-level checks of the pid conditional integration block and their bind
// depends on pidci_pkg and pid_conditional_integration_defines.svh
`include "pid_conditional_integration_defines.svh"

module pidci_checker #(
	parameter int DATA_WIDTH = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [((DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
	input logic [1:0]                         m_axis_tuser,
	input logic                               pready
);

	`PIDCI_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |=> !m_axis_tvalid)
	`PIDCI_ASSERT(a_limit_code, clk, arst_n, !m_axis_tvalid
		|| (m_axis_tuser == pidci_pkg::LIMIT_NONE) || (m_axis_tuser == pidci_pkg::LIMIT_MAX)
		|| (m_axis_tuser == pidci_pkg::LIMIT_MIN))
	`PIDCI_ASSERT(a_pready_high, clk, arst_n, pready)
	`PIDCI_ASSERT_NEXT(a_stall_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind pid_conditional_integration pidci_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_pidci_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser),
	.pready(pready)
);

[tb/pid_conditional_integration_tb.sv]
// self-checking testbench for the pid conditional integration block
// scoreboard class predicts drive and limit state per sample; depends on pidci_pkg and the rtl
`timescale 1ns / 100ps

module pid_conditional_integration_tb;

	localparam int DATA_W = 16;
	localparam int FRAC = 16;
	localparam int ACC_W = 48;
	localparam int ADDR_W = pidci_pkg::APB_AW;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [DATA_W-1:0] drive;
		logic [1:0]        state;
	} drive_result_t;

	typedef enum int {STIM_TRACK, STIM_NOISE, STIM_EXTREME} stim_mode_t;
	typedef enum int {CFG_REALISTIC, CFG_WILD, CFG_TIGHT, CFG_EXTREME} cfg_kind_t;
	typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

	class pid_scoreboard;
		logic signed [pidci_pkg::GAIN_W-1:0] kp, ki, kd;
		logic signed [DATA_W-1:0] lim_lo, lim_hi;
		logic signed [ACC_W-1:0]  integ_acc;
		logic signed [DATA_W-1:0] prev_meas;
		drive_result_t            pending_drives[$];
		int                       mismatches;

		function new();
			kp = '0;
			ki = '0;
			kd = '0;
			lim_lo = {1'b1, {(DATA_W-1){1'b0}}};
			lim_hi = {1'b0, {(DATA_W-1){1'b1}}};
			integ_acc = '0;
			prev_meas = '0;
			mismatches = 0;
		endfunction

		function longint sat_acc(longint x);
			longint top;
			top = (longint'(1) << (ACC_W-1)) - 1;
			if (x > top)
				return top;
			if (x < -top - 1)
				return -top - 1;
			return x;
		endfunction

		function void flag_mismatch(string what, longint expected, longint actual);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s at %0t: expected %0d, got %0d", what, $realtime,
					expected, actual);
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				pidci_pkg::REG_PROP_GAIN: kp = value;
				pidci_pkg::REG_INTEGRAL_GAIN: ki = value;
				pidci_pkg::REG_DERIVATIVE_GAIN: kd = value;
				pidci_pkg::REG_DRIVE_MIN: lim_lo = value[DATA_W-1:0];
				pidci_pkg::REG_DRIVE_MAX: lim_hi = value[DATA_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				pidci_pkg::REG_PROP_GAIN: return kp;
				pidci_pkg::REG_INTEGRAL_GAIN: return ki;
				pidci_pkg::REG_DERIVATIVE_GAIN: return kd;
				pidci_pkg::REG_DRIVE_MIN: return {{(32-DATA_W){1'b0}}, lim_lo};
				pidci_pkg::REG_DRIVE_MAX: return {{(32-DATA_W){1'b0}}, lim_hi};
				default: return '0;
			endcase
		endfunction

		function int pending();
			return pending_drives.size();
		endfunction

		function void note_sample(logic [2*DATA_W-1:0] data);
			longint tgt, meas, err, dmeas, acc;
			longint p_term, i_step, d_term, cand, sum, hi, lo, shifted;
			drive_result_t res;
			tgt = longint'($signed(data[DATA_W-1:0]));
			meas = longint'($signed(data[2*DATA_W-1:DATA_W]));
			err = tgt - meas;
			dmeas = meas - longint'(prev_meas);
			acc = longint'(integ_acc);
			p_term = sat_acc(longint'(kp) * err);
			i_step = sat_acc(longint'(ki) * err);
			d_term = sat_acc(-(longint'(kd) * dmeas));
			cand = sat_acc(acc + i_step);
			sum = sat_acc(sat_acc(p_term + cand) + d_term);
			hi = longint'(lim_hi) * (longint'(1) << FRAC);
			lo = longint'(lim_lo) * (longint'(1) << FRAC);
			prev_meas = data[2*DATA_W-1:DATA_W];
			// conditional integration: when clamped, only let the integrator unwind
			if (sum > hi) begin
				res.drive = lim_hi;
				res.state = pidci_pkg::LIMIT_MAX;
				if (cand < acc)
					integ_acc = cand[ACC_W-1:0];
			end else if (sum < lo) begin
				res.drive = lim_lo;
				res.state = pidci_pkg::LIMIT_MIN;
				if (cand > acc)
					integ_acc = cand[ACC_W-1:0];
			end else begin
				shifted = sum >>> FRAC;
				res.drive = shifted[DATA_W-1:0];
				res.state = pidci_pkg::LIMIT_NONE;
				integ_acc = cand[ACC_W-1:0];
			end
			pending_drives.push_back(res);
		endfunction

		function void check_drive(logic [DATA_W-1:0] drive, logic [1:0] state);
			drive_result_t want;
			if (pending_drives.size() == 0) begin
				flag_mismatch("result with no request waiting, drive", 0, $signed(drive));
				return;
			end
			want = pending_drives.pop_front();
			if (drive !== want.drive)
				flag_mismatch("drive", $signed(want.drive), $signed(drive));
			if (state !== want.state)
				flag_mismatch("limit_state", want.state, state);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [2*DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pid_scoreboard sb;
	bit long_hold_req = 1'b0;
	int cycle_count = 0;
	int burst_left = 0;
	int run_left = 0;
	stim_mode_t run_mode = STIM_TRACK;
	int track_target = 0;
	int track_meas = 0;

	pid_conditional_integration #(
		.DATA_WIDTH(DATA_W),
		.FRAC_BITS(FRAC),
		.ACC_WIDTH(ACC_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),   // target_value, measured_value
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),   // drive
		.m_axis_tuser(m_axis_tuser),   // limit_state
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_drive(m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_sample(s_axis_tdata);
		end
	end

	// receiver: changing ready patterns plus one long hold on request
	initial begin : receiver
		int rx_cycle;
		int hold_count;
		rx_pattern_t rx_mode;
		rx_cycle = 0;
		rx_mode = RX_OPEN;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				hold_count = 0;
				while (hold_count < LONG_HOLD) begin
					@(posedge clk);
					hold_count++;
				end
				long_hold_req = 1'b0;
			end else begin
				if (rx_cycle % 48 == 0)
					rx_mode = rx_pattern_t'($urandom_range(0, 3));
				case (rx_mode)
					RX_OPEN: m_axis_tready <= 1'b1;
					RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ((rx_cycle % 5) < 2);
				endcase
			end
			rx_cycle++;
		end
	end

	function automatic logic [ADDR_W-1:0] reg_addr(pidci_pkg::reg_idx_t r);
		return ADDR_W'(r) << 2;
	endfunction

	function automatic logic [DATA_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return {1'b1, {(DATA_W-1){1'b0}}};
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.write_reg(addr[ADDR_W-1:2], data);
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_registers();
		logic [31:0] got, want;
		for (int r = pidci_pkg::REG_PROP_GAIN; r <= pidci_pkg::REG_DRIVE_MAX; r++) begin
			apb_read(reg_addr(pidci_pkg::reg_idx_t'(r)), got);
			want = sb.reg_value(3'(r));
			if (r >= pidci_pkg::REG_DRIVE_MIN) begin
				if (got[DATA_W-1:0] !== want[DATA_W-1:0])
					sb.flag_mismatch("register readback", want[DATA_W-1:0],
						got[DATA_W-1:0]);
			end else if (got !== want) begin
				sb.flag_mismatch("register readback", want, got);
			end
		end
	endtask

	task automatic set_config(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
			input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
		apb_write(reg_addr(pidci_pkg::REG_PROP_GAIN), p);
		apb_write(reg_addr(pidci_pkg::REG_INTEGRAL_GAIN), i);
		apb_write(reg_addr(pidci_pkg::REG_DERIVATIVE_GAIN), d);
		apb_write(reg_addr(pidci_pkg::REG_DRIVE_MIN), {{(32-DATA_W){lo[DATA_W-1]}}, lo});
		apb_write(reg_addr(pidci_pkg::REG_DRIVE_MAX), {{(32-DATA_W){hi[DATA_W-1]}}, hi});
		check_registers();
	endtask

	// sender works in bursts with random gaps between them
	task automatic send_sample(input logic [DATA_W-1:0] tgt, input logic [DATA_W-1:0] meas);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= $urandom;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {meas, tgt};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly slow tracking of a held setpoint, some noise and some extremes
	task automatic send_random_sample();
		logic [DATA_W-1:0] tgt, meas, raw;
		int sel;
		if (run_left == 0) begin
			run_left = $urandom_range(8, 40);
			sel = $urandom_range(0, 9);
			run_mode = (sel < 7) ? STIM_TRACK : (sel < 9) ? STIM_NOISE : STIM_EXTREME;
			raw = DATA_W'($urandom);
			track_target = $signed(raw);
		end
		run_left--;
		case (run_mode)
			STIM_TRACK: begin
				track_meas = track_meas + (track_target - track_meas) / 8
					+ int'($urandom_range(0, 128)) - 64;
				if (track_meas > 32767)
					track_meas = 32767;
				if (track_meas < -32768)
					track_meas = -32768;
				tgt = track_target[DATA_W-1:0];
				meas = track_meas[DATA_W-1:0];
			end
			STIM_NOISE: begin
				tgt = DATA_W'($urandom);
				meas = DATA_W'($urandom);
			end
			default: begin
				tgt = pick_extreme();
				meas = pick_extreme();
			end
		endcase
		send_sample(tgt, meas);
	endtask

	task automatic apply_random_config(input cfg_kind_t kind);
		logic [31:0] g[3];
		logic [DATA_W-1:0] lo, hi;
		for (int k = 0; k < 3; k++) begin
			case (kind)
				CFG_REALISTIC: g[k] = $urandom_range(0, 4 << FRAC);
				CFG_WILD: g[k] = $urandom;
				CFG_TIGHT: g[k] = $urandom_range(0, 64 << FRAC);
				default: begin
					case ($urandom_range(0, 3))
						0: g[k] = 32'h7fff_ffff;
						1: g[k] = 32'h8000_0000;
						2: g[k] = '0;
						default: g[k] = $urandom;
					endcase
				end
			endcase
			if (kind != CFG_WILD && kind != CFG_EXTREME && $urandom_range(0, 1))
				g[k] = -g[k];
		end
		case (kind)
			CFG_REALISTIC: begin
				lo = DATA_W'(-$urandom_range(100, 32768));
				hi = DATA_W'($urandom_range(100, 32767));
			end
			CFG_WILD: begin
				lo = DATA_W'($urandom);
				hi = DATA_W'($urandom);
			end
			CFG_TIGHT: begin
				lo = DATA_W'(-$urandom_range(0, 2000));
				hi = ($urandom_range(0, 3) == 0) ? lo : DATA_W'($urandom_range(0, 2000));
			end
			default: begin
				lo = ($urandom_range(0, 1)) ? 16'h8000 : 16'h0000;
				hi = ($urandom_range(0, 1)) ? 16'h7fff : 16'h0000;
			end
		endcase
		set_config(g[0], g[1], g[2], lo, hi);
	endtask

	initial begin
		int phase_items;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		check_registers();

		// reset gains are zero, so full-scale error still gives zero drive
		send_sample(16'h7fff, 16'h8000);
		send_sample(16'h8000, 16'h7fff);
		drain_results();

		set_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 16'h8000, 16'h7fff);
		send_sample(16'h0000, 16'h0000);
		send_sample(16'd1000, 16'd900);
		send_sample(-16'sd1000, -16'sd900);
		send_sample(16'h7fff, 16'h8000);
		send_sample(16'h8000, 16'h7fff);
		drain_results();

		// saturating accumulator, integrator held and then unwound
		set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'h8000, 16'h7fff);
		repeat (3) send_sample(16'h7fff, 16'h8000);
		repeat (3) send_sample(16'h8000, 16'h7fff);
		drain_results();

		// minimum above maximum
		set_config(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 16'sd100, -16'sd100);
		send_sample(16'h0000, 16'h0000);
		send_sample(16'd5, 16'h0000);
		send_sample(-16'sd5, 16'h0000);
		send_sample(16'd20000, -16'sd20000);
		drain_results();

		// writes past the last register leave everything alone
		set_config(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000);
		apb_write(ADDR_W'(5 << 2), $urandom);
		apb_write(ADDR_W'(7 << 2), $urandom);
		check_registers();
		send_sample(16'd3, 16'd1);
		send_sample(-16'sd3, 16'd1);
		drain_results();

		for (int phase = 0; phase < 8; phase++) begin
			apply_random_config(cfg_kind_t'(phase % 4));
			phase_items = $urandom_range(110, 140);
			if (phase == 1)
				long_hold_req = 1'b1;
			for (int n = 0; n < phase_items; n++) begin
				if (phase == 3 && n == phase_items / 2)
					drain_results();
				send_random_sample();
			end
			drain_results();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/pidci_pkg.sv
rtl/pidci_front.sv
rtl/pidci_queue.sv
rtl/pidci_back.sv
rtl/pid_conditional_integration.sv
rtl/pidci_checker.sv
tb/pid_conditional_integration_tb.sv
